FILE: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the triangle scanline rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int FRAC_BITS_DEF     = 4;

  // magnitude of an edge numerator and width of its divisor, sized for FRAC_BITS up to 8
  localparam int MAG_W = 30;
  localparam int DEN_W = 20;
  localparam int CD_W  = 16;

  typedef struct packed {
    logic [11:0] x0;
    logic [9:0]  y0;
    logic [11:0] x1;
    logic [9:0]  y1;
    logic [11:0] x2;
    logic [9:0]  y2;
    logic [3:0]  color;
    logic [5:0]  ystart;
    logic [6:0]  yend;
    logic        short_left;
    logic        empty;
  } setup_t;

  typedef struct packed {
    logic [5:0] row;
    logic [8:0] span_start;
    logic [8:0] span_end;
    logic       span_valid;
    logic [3:0] span_color;
    logic       last_span;
  } result_t;

endpackage

FILE: rtl/tsr_queue.sv
// ----------------------------------------------------------------------------
// tsr_queue
// Small synchronous FIFO used between the front end, back end and outputs.
// ----------------------------------------------------------------------------
module tsr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/tsr_front.sv
// ----------------------------------------------------------------------------
// tsr_front
// Accepts triangles, sorts vertices by y, finds the row range and winding.
// ----------------------------------------------------------------------------
module tsr_front #(
  parameter int FRAC_BITS     = tsr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_HEIGHT = tsr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [11:0]     in_x0,
  input  logic [9:0]      in_y0,
  input  logic [11:0]     in_x1,
  input  logic [9:0]      in_y1,
  input  logic [11:0]     in_x2,
  input  logic [9:0]      in_y2,
  input  logic [3:0]      in_fill_color,
  input  logic            q_full,
  output logic            q_push,
  output tsr_pkg::setup_t q_data
);

  localparam logic [11:0] ONE = 12'(1 << FRAC_BITS);
  localparam logic [11:0] HGT = 12'(SCREEN_HEIGHT);

  logic [11:0] sx [3];
  logic [9:0]  sy [3];
  logic [11:0] tx;
  logic [9:0]  ty;

  logic [11:0] x_r [3];
  logic [9:0]  y_r [3];
  logic [3:0]  col_r;
  logic        v_r;
  logic        accept;

  logic [11:0] ys_w, ye_w, ye_c;
  logic signed [12:0] dx1, dx2;
  logic signed [10:0] dy1, dy2;
  logic signed [24:0] cross_w;

  // stable compare-swap network, equal y keeps input order
  always_comb begin
    sx[0] = in_x0; sx[1] = in_x1; sx[2] = in_x2;
    sy[0] = in_y0; sy[1] = in_y1; sy[2] = in_y2;
    tx = '0;
    ty = '0;
    if (sy[1] < sy[0]) begin
      ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
    end
    if (sy[2] < sy[1]) begin
      ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
      tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
    end
    if (sy[1] < sy[0]) begin
      ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
    end
  end

  assign accept  = in_push && !in_full;
  assign in_full = v_r && q_full;
  assign q_push  = v_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= sx;
      y_r   <= sy;
      col_r <= in_fill_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (!q_full) begin
      v_r <= 1'b0;
    end
  end

  // ceil(v - 0.5) in pixels, clamped at zero; the end row is also clamped to the screen height
  always_comb begin
    ys_w = ({1'b0, y_r[0], 1'b0} <= ONE) ? '0
         : 12'(({1'b0, y_r[0], 1'b0} + ONE - 12'd1) >> (FRAC_BITS + 1));
    ye_w = ({1'b0, y_r[2], 1'b0} <= ONE) ? '0
         : 12'(({1'b0, y_r[2], 1'b0} + ONE - 12'd1) >> (FRAC_BITS + 1));
    ye_c = (ye_w > HGT) ? HGT : ye_w;
  end

  always_comb begin
    dx1     = $signed({1'b0, x_r[1]}) - $signed({1'b0, x_r[0]});
    dx2     = $signed({1'b0, x_r[2]}) - $signed({1'b0, x_r[0]});
    dy1     = $signed({1'b0, y_r[1]}) - $signed({1'b0, y_r[0]});
    dy2     = $signed({1'b0, y_r[2]}) - $signed({1'b0, y_r[0]});
    cross_w = 25'(dx1 * dy2) - 25'(dx2 * dy1);
  end

  always_comb begin
    q_data.x0         = x_r[0];
    q_data.y0         = y_r[0];
    q_data.x1         = x_r[1];
    q_data.y1         = y_r[1];
    q_data.x2         = x_r[2];
    q_data.y2         = y_r[2];
    q_data.color      = col_r;
    q_data.ystart     = ys_w[5:0];
    q_data.yend       = ye_c[6:0];
    q_data.short_left = cross_w < 0;
    q_data.empty      = (ye_c <= ys_w);
  end

endmodule

FILE: rtl/tsr_edge.sv
// ----------------------------------------------------------------------------
// tsr_edge
// Edge column at a row center: two products, a sum, then radix-2 ceil divide.
// ----------------------------------------------------------------------------
module tsr_edge #(
  parameter int FRAC_BITS    = tsr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH = tsr_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [11:0]               xa,
  input  logic [9:0]                ya,
  input  logic [11:0]               xb,
  input  logic [9:0]                yb,
  input  logic [tsr_pkg::CD_W-1:0]  cd,
  output logic                      done,
  output logic [8:0]                col
);

  localparam int MW = tsr_pkg::MAG_W;
  localparam int DW = tsr_pkg::DEN_W;
  localparam int KW = $clog2(MW);
  localparam logic [MW:0] SW = (MW + 1)'(SCREEN_WIDTH);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_DIV} state_t;

  state_t state_r;
  logic   done_r;
  logic [KW-1:0] cnt_r;

  logic [9:0]          d_w;
  logic signed [14:0]  a1_w, a1_r;
  logic signed [10:0]  ds_r;
  logic signed [12:0]  a2_r;
  logic signed [16:0]  b2_r;
  logic                dz_r;
  logic [DW-1:0]       den_r;
  logic signed [25:0]  p1_r;
  logic signed [29:0]  p2_r;
  logic signed [30:0]  num_w;
  logic                pos_r;
  logic [MW-1:0]       qm_r;
  logic [DW-1:0]       rem_r;
  logic [DW:0]         trial;
  logic [MW:0]         qc;

  assign d_w  = yb - ya;
  assign a1_w = $signed({2'b00, xa, 1'b0}) - $signed(15'(1 << FRAC_BITS));
  assign num_w = dz_r ? 31'(a1_r) : (31'(p1_r) + 31'(p2_r));
  assign trial = {rem_r, qm_r[MW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_SUM;
        S_SUM: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == KW'(MW - 1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        a1_r  <= a1_w;
        ds_r  <= $signed({1'b0, d_w});
        a2_r  <= $signed({1'b0, xb}) - $signed({1'b0, xa});
        b2_r  <= $signed({1'b0, cd}) - $signed({6'b0, ya, 1'b0});
        dz_r  <= (d_w == '0);
        // horizontal edge falls back to rounding xa alone
        den_r <= (d_w == '0) ? DW'(2 << FRAC_BITS) : (DW'(d_w) << (FRAC_BITS + 1));
      end
      S_MUL: begin
        p1_r <= a1_r * ds_r;
        p2_r <= a2_r * b2_r;
      end
      S_SUM: begin
        pos_r <= num_w > 0;
        qm_r  <= num_w[30] ? MW'(-num_w) : MW'(num_w);
        rem_r <= '0;
      end
      S_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DW'(trial - {1'b0, den_r});
          qm_r  <= {qm_r[MW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DW-1:0];
          qm_r  <= {qm_r[MW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // non-positive numerator always clamps to column zero
  assign qc   = {1'b0, qm_r} + (MW + 1)'(rem_r != '0);
  assign col  = !pos_r ? 9'd0 : (qc > SW) ? 9'(SW) : 9'(qc);
  assign done = done_r;

endmodule

FILE: rtl/tsr_back.sv
// ----------------------------------------------------------------------------
// tsr_back
// Walks the rows of one triangle and emits a span per row; an empty one gets one invalid span.
// ----------------------------------------------------------------------------
module tsr_back #(
  parameter int FRAC_BITS    = tsr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH = tsr_pkg::SCREEN_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  tsr_pkg::setup_t  q_data,
  output logic             q_pop,
  input  logic             out_full,
  output logic             res_push,
  output tsr_pkg::result_t res_data
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} state_t;

  state_t           state_r;
  tsr_pkg::setup_t  rec_r;
  logic [5:0]       row_r;
  tsr_pkg::result_t res_r;

  logic [tsr_pkg::CD_W-1:0] cd;
  logic       use_top, last_row;
  logic       start, l_done, s_done;
  logic [8:0] l_col, s_col;
  logic [11:0] s_xa, s_xb;
  logic [9:0]  s_ya, s_yb;

  assign cd       = tsr_pkg::CD_W'({row_r, 1'b1}) << FRAC_BITS;
  assign use_top  = cd < {5'b0, rec_r.y1, 1'b0};
  assign last_row = ({1'b0, row_r} + 7'd1) == rec_r.yend;
  assign start    = (state_r == S_START);
  assign s_xa     = use_top ? rec_r.x0 : rec_r.x1;
  assign s_ya     = use_top ? rec_r.y0 : rec_r.y1;
  assign s_xb     = use_top ? rec_r.x1 : rec_r.x2;
  assign s_yb     = use_top ? rec_r.y1 : rec_r.y2;

  tsr_edge #(.FRAC_BITS(FRAC_BITS), .SCREEN_WIDTH(SCREEN_WIDTH)) u_long (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .xa   (rec_r.x0),
    .ya   (rec_r.y0),
    .xb   (rec_r.x2),
    .yb   (rec_r.y2),
    .cd   (cd),
    .done (l_done),
    .col  (l_col)
  );

  tsr_edge #(.FRAC_BITS(FRAC_BITS), .SCREEN_WIDTH(SCREEN_WIDTH)) u_short (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .xa   (s_xa),
    .ya   (s_ya),
    .xb   (s_xb),
    .yb   (s_yb),
    .cd   (cd),
    .done (s_done),
    .col  (s_col)
  );

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign res_push = (state_r == S_EMIT) && !out_full;
  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            rec_r <= q_data;
            row_r <= q_data.ystart;
            if (q_data.empty) begin
              res_r   <= '{row: '0, span_start: '0, span_end: '0, span_valid: 1'b0,
                           span_color: q_data.color, last_span: 1'b1};
              state_r <= S_EMIT;
            end else begin
              state_r <= S_START;
            end
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (l_done) begin
            res_r.row        <= row_r;
            res_r.span_start <= rec_r.short_left ? s_col : l_col;
            res_r.span_end   <= rec_r.short_left ? l_col : s_col;
            res_r.span_valid <= 1'b1;
            res_r.span_color <= rec_r.color;
            res_r.last_span  <= last_row;
            state_r          <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_full) begin
            if (res_r.last_span) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_edges_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    l_done == s_done)
    else $error("edge units out of step");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && !res_data.span_valid |-> res_data.last_span)
    else $error("empty-triangle result not marked last");

  a_more_rows: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && !res_data.last_span |=> state_r == S_START)
    else $error("row walk stopped before last span");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> ({1'b0, row_r} < rec_r.yend))
    else $error("row beyond end of triangle");

endmodule

FILE: rtl/triangle_scanline_rasterizer_top.sv
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer_top
// Triangle scan conversion with top-left rule; one span result per row.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  in_      | in_push / in_full | in_x0..in_y2, in_fill_color
//  out_     | out_pop / out_empty | out_row, out_span_*, out_last_span
//
// Setup is registered once in the front end; a 2-entry queue decouples it.
// The back end takes each triangle from the setup queue, then for each row
// starts both edge dividers, waits for them and emits the span.
// A triangle covering no rows gives a single invalid result marked last.
// Reset (rst_n low, synchronous) empties all queues and idles both ends.
// A full result queue stalls the row walk; the front keeps accepting until
// its setup queue fills.
// ----------------------------------------------------------------------------
module triangle_scanline_rasterizer_top #(
  parameter int SCREEN_WIDTH  = tsr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tsr_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [11:0] in_x0,
  input  logic [9:0]  in_y0,
  input  logic [11:0] in_x1,
  input  logic [9:0]  in_y1,
  input  logic [11:0] in_x2,
  input  logic [9:0]  in_y2,
  input  logic [3:0]  in_fill_color,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [5:0]  out_row,
  output logic [8:0]  out_span_start,
  output logic [8:0]  out_span_end,
  output logic        out_span_valid,
  output logic [3:0]  out_span_color,
  output logic        out_last_span
);

  localparam int SW_W = $bits(tsr_pkg::setup_t);
  localparam int RW_W = $bits(tsr_pkg::result_t);

  tsr_pkg::setup_t  f_data, b_data;
  tsr_pkg::result_t r_data, o_data;
  logic f_push, sq_full, sq_empty, b_pop;
  logic r_push, oq_full;

  tsr_front #(.FRAC_BITS(FRAC_BITS), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_x0        (in_x0),
    .in_y0        (in_y0),
    .in_x1        (in_x1),
    .in_y1        (in_y1),
    .in_x2        (in_x2),
    .in_y2        (in_y2),
    .in_fill_color(in_fill_color),
    .q_full       (sq_full),
    .q_push       (f_push),
    .q_data       (f_data)
  );

  tsr_queue #(.W(SW_W), .DEPTH(2)) u_setup_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .wdata(f_data),
    .pop  (b_pop),
    .rdata(b_data),
    .full (sq_full),
    .empty(sq_empty)
  );

  tsr_back #(.FRAC_BITS(FRAC_BITS), .SCREEN_WIDTH(SCREEN_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (sq_empty),
    .q_data  (b_data),
    .q_pop   (b_pop),
    .out_full(oq_full),
    .res_push(r_push),
    .res_data(r_data)
  );

  tsr_queue #(.W(RW_W), .DEPTH(2)) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (r_push),
    .wdata(r_data),
    .pop  (out_pop),
    .rdata(o_data),
    .full (oq_full),
    .empty(out_empty)
  );

  assign out_row        = o_data.row;
  assign out_span_start = o_data.span_start;
  assign out_span_end   = o_data.span_end;
  assign out_span_valid = o_data.span_valid;
  assign out_span_color = o_data.span_color;
  assign out_last_span  = o_data.last_span;

endmodule

FILE: verif/tsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_checker
// Watches both channels of the rasterizer, computes the spans each accepted
// triangle should produce and compares every popped span in order.
// ----------------------------------------------------------------------------
module tsr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [11:0] in_x0,
  input  logic [9:0]  in_y0,
  input  logic [11:0] in_x1,
  input  logic [9:0]  in_y1,
  input  logic [11:0] in_x2,
  input  logic [9:0]  in_y2,
  input  logic [3:0]  in_fill_color,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [5:0]  out_row,
  input  logic [8:0]  out_span_start,
  input  logic [8:0]  out_span_end,
  input  logic        out_span_valid,
  input  logic [3:0]  out_span_color,
  input  logic        out_last_span,
  output int          fail_count,
  output int          pending_spans,
  output int          spans_seen,
  output int          valid_spans_seen
);

  localparam longint ONE = 16;
  localparam longint WIDTH = 256;
  localparam longint HEIGHT = 64;

  tsr_pkg::result_t span_q[$];

  function automatic longint div_up(longint num, longint den);
    longint q;
    q = num / den;
    if (num > 0 && (num % den) != 0) q = q + 1;
    return q;
  endfunction

  function automatic longint center_col(longint v);
    return div_up(2 * v - ONE, 2 * ONE);
  endfunction

  function automatic longint edge_x(longint xa, longint ya, longint xb, longint yb,
                                    longint cd);
    longint d;
    d = yb - ya;
    if (d <= 0) return center_col(xa);
    return div_up((2 * xa - ONE) * d + (xb - xa) * (cd - 2 * ya), d * 2 * ONE);
  endfunction

  function automatic logic [8:0] clip_col(longint c);
    if (c < 0) return 9'd0;
    if (c > WIDTH) return 9'(WIDTH);
    return 9'(c);
  endfunction

  task automatic queue_spans(longint ax, longint ay, longint bx, longint by,
                             longint cx, longint cy, logic [3:0] color);
    longint vx[3], vy[3], t, ys, ye, xprod, y, cd, xl, xs;
    tsr_pkg::result_t r;
    vx[0] = ax; vy[0] = ay; vx[1] = bx; vy[1] = by; vx[2] = cx; vy[2] = cy;
    for (int p = 0; p < 3; p++) begin
      int i;
      i = (p == 1) ? 1 : 0;
      if (vy[i + 1] < vy[i]) begin
        t = vy[i]; vy[i] = vy[i + 1]; vy[i + 1] = t;
        t = vx[i]; vx[i] = vx[i + 1]; vx[i + 1] = t;
      end
    end
    ys = center_col(vy[0]);
    ye = center_col(vy[2]);
    if (ys < 0) ys = 0;
    if (ye > HEIGHT) ye = HEIGHT;
    if (ye > ys + 64) ye = ys + 64;
    if (ye <= ys) begin
      r = '0;
      r.span_color = color;
      r.last_span = 1'b1;
      span_q.push_back(r);
      return;
    end
    xprod = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[1] - vy[0]);
    for (y = ys; y < ye; y++) begin
      cd = (2 * y + 1) * ONE;
      xl = edge_x(vx[0], vy[0], vx[2], vy[2], cd);
      if (cd < 2 * vy[1]) xs = edge_x(vx[0], vy[0], vx[1], vy[1], cd);
      else xs = edge_x(vx[1], vy[1], vx[2], vy[2], cd);
      r.row = 6'(y);
      r.span_start = clip_col(xprod < 0 ? xs : xl);
      r.span_end = clip_col(xprod < 0 ? xl : xs);
      r.span_valid = 1'b1;
      r.span_color = color;
      r.last_span = (y + 1 == ye);
      span_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    tsr_pkg::result_t want;
    if (!rst_n) begin
      fail_count <= 0;
      spans_seen <= 0;
      valid_spans_seen <= 0;
      span_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        spans_seen <= spans_seen + 1;
        if (out_span_valid) valid_spans_seen <= valid_spans_seen + 1;
        if (span_q.size() == 0) begin
          $display("%0t: unexpected span row=%0d start=%0d end=%0d", $time, out_row,
                   out_span_start, out_span_end);
          fail_count <= fail_count + 1;
        end else begin
          want = span_q.pop_front();
          if (want.row !== out_row || want.span_start !== out_span_start ||
              want.span_end !== out_span_end || want.span_valid !== out_span_valid ||
              want.span_color !== out_span_color || want.last_span !== out_last_span) begin
            $display("%0t: span mismatch expected row=%0d start=%0d end=%0d v=%0b c=%0d l=%0b",
                     $time, want.row, want.span_start, want.span_end, want.span_valid,
                     want.span_color, want.last_span);
            $display("%0t:                 actual row=%0d start=%0d end=%0d v=%0b c=%0d l=%0b",
                     $time, out_row, out_span_start, out_span_end, out_span_valid,
                     out_span_color, out_last_span);
            fail_count <= fail_count + 1;
          end
        end
      end
      // queued after the pop so a same-edge transfer never matches a fresh triangle
      if (in_push && !in_full)
        queue_spans(in_x0, in_y0, in_x1, in_y1, in_x2, in_y2, in_fill_color);
    end
    pending_spans <= span_q.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives triangles into the rasterizer with bursty pushes and stalled pops;
// a checker beside the block predicts and compares every span.
// ----------------------------------------------------------------------------
module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [11:0] in_x0 = '0, in_x1 = '0, in_x2 = '0;
  logic [9:0]  in_y0 = '0, in_y1 = '0, in_y2 = '0;
  logic [3:0]  in_fill_color = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [5:0]  out_row;
  logic [8:0]  out_span_start, out_span_end;
  logic        out_span_valid, out_last_span;
  logic [3:0]  out_span_color;
  int          fail_count, pending_spans, spans_seen, valid_spans_seen;
  int          tri_count = 0;
  longint      cycle_count = 0;
  logic        stim_done = 1'b0;

  localparam longint CYCLE_LIMIT = 4_000_000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  triangle_scanline_rasterizer_top dut (.*);

  tsr_checker chk (.*);

  // receiver stalls follow a mode that changes now and then
  int pop_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) pop_mode <= $urandom_range(0, 3);
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      2: out_pop <= ($urandom_range(0, 1) != 0);
      default: out_pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_tri(logic [11:0] ax, logic [9:0] ay, logic [11:0] bx,
                          logic [9:0] by, logic [11:0] cx, logic [9:0] cy,
                          logic [3:0] color);
    in_x0 <= ax; in_y0 <= ay; in_x1 <= bx; in_y1 <= by;
    in_x2 <= cx; in_y2 <= cy; in_fill_color <= color;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tri_count++;
  endtask

  task automatic idle(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // mostly small on-screen triangles, some raw noise, some wide nearly flat ones
  task automatic push_random;
    int kind;
    logic [11:0] bx;
    logic [9:0]  by;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      bx = 12'($urandom_range(0, 4095));
      by = 10'($urandom_range(0, 1023 - 160));
      push_tri(bx, by, 12'(bx + $urandom_range(0, 200) - 100),
               10'(by + $urandom_range(0, 160)), 12'(bx + $urandom_range(0, 200) - 100),
               10'(by + $urandom_range(0, 160)), 4'($urandom));
    end else if (kind < 8) begin
      push_tri(12'($urandom), 10'($urandom_range(0, 1023)), 12'($urandom),
               10'($urandom_range(0, 1023)), 12'($urandom), 10'($urandom_range(0, 1023)),
               4'($urandom));
    end else begin
      by = 10'($urandom_range(0, 1023));
      push_tri(12'($urandom), by, 12'($urandom), by, 12'($urandom),
               10'(by + $urandom_range(0, 20)), 4'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners and extremes
    push_tri(12'd0, 10'd0, 12'd0, 10'd0, 12'd0, 10'd0, 4'd0);
    push_tri(12'hfff, 10'h3ff, 12'hfff, 10'h3ff, 12'hfff, 10'h3ff, 4'hf);
    push_tri(12'd0, 10'd0, 12'hfff, 10'd0, 12'd0, 10'h3ff, 4'd5);
    push_tri(12'hfff, 10'h3ff, 12'd0, 10'd0, 12'hfff, 10'd0, 4'ha);
    push_tri(12'd0, 10'h3ff, 12'hfff, 10'h3ff, 12'd2048, 10'd0, 4'h3);
    // rows near the bottom of the screen
    push_tri(12'd100, 10'd900, 12'd500, 10'd1000, 12'd300, 10'd1023, 4'h6);
    // flat top and flat bottom, both windings
    push_tri(12'd160, 10'd40, 12'd800, 10'd40, 12'd480, 10'd300, 4'h1);
    push_tri(12'd800, 10'd40, 12'd160, 10'd40, 12'd480, 10'd300, 4'h2);
    push_tri(12'd480, 10'd40, 12'd160, 10'd300, 12'd800, 10'd300, 4'h4);
    push_tri(12'd480, 10'd40, 12'd800, 10'd300, 12'd160, 10'd300, 4'h8);
    // thin sliver covering no rows, and one exactly on a pixel center
    push_tri(12'd100, 10'd17, 12'd500, 10'd20, 12'd300, 10'd23, 4'h9);
    push_tri(12'd100, 10'd24, 12'd500, 10'd24, 12'd300, 10'd40, 4'hc);
    // degenerate lines and all vertices with equal y in a mixed order
    push_tri(12'd50, 10'd10, 12'd50, 10'd200, 12'd50, 10'd100, 4'h7);
    push_tri(12'd900, 10'd200, 12'd30, 10'd200, 12'd400, 10'd200, 4'hb);
    // against the right edge and a span with no pixels
    push_tri(12'd4000, 10'd16, 12'd4095, 10'd100, 12'd3900, 10'd120, 4'hd);
    push_tri(12'd300, 10'd50, 12'd303, 10'd90, 12'd306, 10'd130, 4'he);
    push_tri(12'd1234, 10'd555, 12'd2100, 10'd321, 12'd3000, 10'd700, 4'h5);
    idle(1);

    // let everything drain before the random part
    while (pending_spans != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    while (tri_count < 450) begin
      repeat ($urandom_range(1, 12)) push_random();
      if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 40));
      if (tri_count > 200 && tri_count < 215) begin
        idle(1);
        while (pending_spans != 0) @(posedge clk);
      end
    end
    idle(1);

    while (pending_spans != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d triangles; checked %0d spans, %0d of them covering a row.",
             tri_count, spans_seen, valid_spans_seen);
    if (fail_count == 0 && pending_spans == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
